// ===== sv/rrs_pkg.sv =====
// Shared widths, register indexes and reset values of the ring row span generator.
package rrs_pkg;

  localparam int ROW_W = 12;
  localparam int COL_W = 12;
  localparam int PIX_W = 8;
  localparam int CFG_W = 14;
  localparam int IDX_W = 3;

  // Square root lanes: the root of the outer radicand needs 13 bits.
  localparam int SQRT_ROOT_W = 13;
  localparam int SQRT_STEPS  = 4;

  typedef enum logic [IDX_W-1:0] {
    REG_IMAGE_WIDTH    = 3'd0,
    REG_IMAGE_HEIGHT   = 3'd1,
    REG_CENTER_X       = 3'd2,
    REG_CENTER_Y       = 3'd3,
    REG_RADIUS         = 3'd4,
    REG_RING_THICKNESS = 3'd5,
    REG_FILL_LEVEL     = 3'd6
  } reg_idx_t;

  localparam logic [12:0] RST_IMAGE_WIDTH    = 13'd640;
  localparam logic [12:0] RST_IMAGE_HEIGHT   = 13'd480;
  localparam logic [13:0] RST_CENTER_X       = 14'd0;
  localparam logic [13:0] RST_CENTER_Y       = 14'd0;
  localparam logic [11:0] RST_RADIUS         = 12'd0;
  localparam logic [7:0]  RST_RING_THICKNESS = 8'd1;
  localparam logic [7:0]  RST_FILL_LEVEL     = 8'd128;

endpackage

// ===== sv/rrs_row_if.sv =====
// Input channel interface: one row number per beat.
interface rrs_row_if;
  logic                      valid;
  logic                      ready;
  logic [rrs_pkg::ROW_W-1:0] row_index;

  modport source (output valid, output row_index, input ready);
  modport sink   (input valid, input row_index, output ready);
endinterface

// ===== sv/rrs_span_if.sv =====
// Output channel interface: one horizontal span per beat.
interface rrs_span_if;
  logic                      valid;
  logic                      ready;
  logic [rrs_pkg::ROW_W-1:0] span_row;
  logic [rrs_pkg::COL_W-1:0] span_start;
  logic [rrs_pkg::COL_W-1:0] span_end;
  logic [rrs_pkg::PIX_W-1:0] pixel_value;
  logic                      last_span;

  modport source (output valid, output span_row, output span_start, output span_end,
                  output pixel_value, output last_span, input ready);
  modport sink   (input valid, input span_row, input span_start, input span_end,
                  input pixel_value, input last_span, output ready);
endinterface

// ===== sv/rrs_isqrt.sv =====
// Pipelined digit-by-digit integer square root, a fixed number of digits per stage.
module rrs_isqrt #(
  parameter int ROOT_W = 13,
  parameter int STEP_N = 4
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [2*ROOT_W-1:0]   radicand,
  output logic [ROOT_W-1:0]     root
);

  localparam int STAGES = (ROOT_W + STEP_N - 1) / STEP_N;
  localparam int PAD_W  = STAGES * STEP_N;
  localparam int REM_W  = PAD_W + 2;
  localparam int OP_W   = 2 * PAD_W;

  logic [PAD_W-1:0] rt_q [STAGES];
  logic [REM_W-1:0] rm_q [STAGES];
  logic [OP_W-1:0]  op_q [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic [PAD_W-1:0] rt_in;
    logic [PAD_W-1:0] rt_c;
    logic [REM_W-1:0] rm_in;
    logic [REM_W-1:0] rm_c;
    logic [REM_W-1:0] trial;
    logic [OP_W-1:0]  op_in;
    logic [OP_W-1:0]  op_c;

    if (s == 0) begin : g_first
      assign rt_in = '0;
      assign rm_in = '0;
      assign op_in = OP_W'(radicand);
    end else begin : g_next
      assign rt_in = rt_q[s-1];
      assign rm_in = rm_q[s-1];
      assign op_in = op_q[s-1];
    end

    // Each step brings down two radicand bits and decides one root bit.
    always_comb begin
      rt_c  = rt_in;
      rm_c  = rm_in;
      op_c  = op_in;
      trial = '0;
      for (int j = 0; j < STEP_N; j++) begin
        rm_c  = {rm_c[REM_W-3:0], op_c[OP_W-1 -: 2]};
        op_c  = {op_c[OP_W-3:0], 2'b00};
        trial = {rt_c, 2'b01};
        if (rm_c >= trial) begin
          rm_c = rm_c - trial;
          rt_c = {rt_c[PAD_W-2:0], 1'b1};
        end else begin
          rt_c = {rt_c[PAD_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rt_q[s] <= rt_c;
        rm_q[s] <= rm_c;
        op_q[s] <= op_c;
      end
    end
  end

  assign root = rt_q[STAGES-1][ROOT_W-1:0];

endmodule

// ===== sv/ring_row_span_generator.sv =====
// Ring row span generator: spans that a configured ring covers on one image row.
// A row's beat passes stages 1 to 4, the square-root stages and the span-end register to
// the output register. One row per cycle when a row gives one span or none and the output does
// not stall; a two-span row holds the input while its first span leaves, the single output
// register sending one span a cycle. Reset (rst, synchronous, active high) clears every valid
// bit and loads the register defaults. Derived values, and the squared radii from them, are registered.
module ring_row_span_generator #(
  parameter int MAX_DIM = 4096
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [rrs_pkg::IDX_W-1:0]  cfg_index,
  input  logic [rrs_pkg::CFG_W-1:0]  cfg_data,
  rrs_row_if.sink                    row_in,
  rrs_span_if.source                 span_out
);

  localparam int ROOT_W    = rrs_pkg::SQRT_ROOT_W;
  localparam int SQ_STAGES = (ROOT_W + rrs_pkg::SQRT_STEPS - 1) / rrs_pkg::SQRT_STEPS;
  // Width and height registers hold at most 8191, so the saturation limit stops there.
  localparam logic [12:0] DIM_LIM = (MAX_DIM > 8191) ? 13'd8191 : 13'(MAX_DIM);

  // Clamp a signed value into [0, mx].
  function automatic logic [12:0] clamp_u(input logic signed [15:0] v, input logic [12:0] mx);
    logic [12:0] r;
    if (v < 16'sd0) begin
      r = '0;
    end else if (v > $signed({3'b000, mx})) begin
      r = mx;
    end else begin
      r = v[12:0];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Configuration registers.
  // ---------------------------------------------------------------------------------------
  logic [12:0]        image_width;
  logic [12:0]        image_height;
  logic signed [13:0] center_x;
  logic signed [13:0] center_y;
  logic [11:0]        radius;
  logic [7:0]         ring_thickness;
  logic [7:0]         fill_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= rrs_pkg::RST_IMAGE_WIDTH;
      image_height   <= rrs_pkg::RST_IMAGE_HEIGHT;
      center_x       <= rrs_pkg::RST_CENTER_X;
      center_y       <= rrs_pkg::RST_CENTER_Y;
      radius         <= rrs_pkg::RST_RADIUS;
      ring_thickness <= rrs_pkg::RST_RING_THICKNESS;
      fill_level     <= rrs_pkg::RST_FILL_LEVEL;
    end else if (cfg_we) begin
      unique case (rrs_pkg::reg_idx_t'(cfg_index))
        rrs_pkg::REG_IMAGE_WIDTH:    image_width    <= cfg_data[12:0];
        rrs_pkg::REG_IMAGE_HEIGHT:   image_height   <= cfg_data[12:0];
        rrs_pkg::REG_CENTER_X:       center_x       <= cfg_data;
        rrs_pkg::REG_CENTER_Y:       center_y       <= cfg_data;
        rrs_pkg::REG_RADIUS:         radius         <= cfg_data[11:0];
        rrs_pkg::REG_RING_THICKNESS: ring_thickness <= cfg_data[7:0];
        rrs_pkg::REG_FILL_LEVEL:     fill_level     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------------------
  // Derived ring geometry. Registers are to change only while the block is idle; the user must
  // keep to this, the block itself does not enforce it. These values are recomputed every cycle;
  // the first level is used from the second pipeline stage on and the squared radii from the fourth.
  // ---------------------------------------------------------------------------------------
  logic [12:0]        w_sat, h_sat;
  logic [7:0]         half_in, half_out;
  logic [12:0]        outer_c;
  logic [11:0]        inner_c;
  logic signed [15:0] top_c, lo_raw, hi_raw;

  logic [12:0] d_wmax, d_outer, d_lo, d_hi;
  logic [11:0] d_inner;
  logic [24:0] d_osq;
  logic [23:0] d_isq;

  always_comb begin
    w_sat    = (image_width == 13'd0) ? 13'd1 :
               ((image_width > DIM_LIM) ? DIM_LIM : image_width);
    h_sat    = (image_height == 13'd0) ? 13'd1 :
               ((image_height > DIM_LIM) ? DIM_LIM : image_height);
    // Floor half of the thickness goes inward, the ceiling half outward.
    half_in  = {1'b0, ring_thickness[7:1]};
    half_out = ring_thickness - half_in;
    outer_c  = {1'b0, radius} + {5'd0, half_out};
    inner_c  = (radius >= {4'd0, half_in}) ? (radius - {4'd0, half_in}) : 12'd0;
    top_c    = $signed({{2{center_y[13]}}, center_y}) - $signed({4'd0, radius});
    lo_raw   = top_c - $signed({8'd0, half_out});
    hi_raw   = top_c + $signed({2'b00, outer_c, 1'b0}) - 16'sd1;
  end

  always_ff @(posedge clk) begin
    d_wmax  <= w_sat - 13'd1;
    d_outer <= outer_c;
    d_inner <= inner_c;
    d_lo    <= clamp_u(lo_raw, h_sat - 13'd1);
    d_hi    <= clamp_u(hi_raw, h_sat - 13'd1);
    d_osq   <= 25'(d_outer * d_outer);
    d_isq   <= d_inner * d_inner;
  end

  // ---------------------------------------------------------------------------------------
  // Pipeline control. All stages move together; they stall only while the output register
  // still holds a span that has not been taken.
  // ---------------------------------------------------------------------------------------
  logic adv;
  logic e_valid, e_phase, e_two;
  logic done;

  assign done         = e_valid && span_out.ready && (!e_two || e_phase);
  assign adv          = !e_valid || done;
  assign row_in.ready = adv && !rst;

  // Stage 1: capture the row.
  logic        v1;
  logic [11:0] y1;

  // Stage 2: row window and vertical offset from the center.
  logic               v2, win2;
  logic [11:0]        y2;
  logic signed [14:0] dy2;
  logic signed [14:0] dy_c;

  // Stage 3: squared offset.
  logic        v3, win3;
  logic [11:0] y3;
  logic [27:0] dyy3;
  logic [14:0] dneg;
  logic [13:0] dmag;

  // Stage 4: radicands of both circles.
  logic        v4, win4, om4, im4;
  logic [11:0] y4;
  logic [25:0] orad4, irad4;
  logic signed [28:0] osub, isub;

  assign dy_c = $signed({3'b000, y1}) - $signed({center_y[13], center_y});
  assign dneg = 15'(-dy2);
  assign dmag = dy2[14] ? dneg[13:0] : dy2[13:0];
  assign osub = $signed({4'd0, d_osq}) - $signed({1'b0, dyy3});
  assign isub = $signed({5'd0, d_isq}) - $signed({1'b0, dyy3});

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (adv) begin
      v1 <= row_in.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      y1    <= row_in.row_index;
      y2    <= y1;
      win2  <= ({1'b0, y1} >= d_lo) && ({1'b0, y1} <= d_hi);
      dy2   <= dy_c;
      y3    <= y2;
      win3  <= win2;
      dyy3  <= dmag * dmag;
      y4    <= y3;
      win4  <= win3;
      om4   <= osub[28];
      im4   <= isub[28];
      orad4 <= osub[25:0];
      irad4 <= isub[25:0];
    end
  end

  // ---------------------------------------------------------------------------------------
  // Half-widths of the outer and inner circle, one square-root lane each. Row data rides
  // alongside in a delay line of the same depth.
  // ---------------------------------------------------------------------------------------
  logic [ROOT_W-1:0] dxo, dxi;

  rrs_isqrt #(.ROOT_W(ROOT_W), .STEP_N(rrs_pkg::SQRT_STEPS)) u_sqrt_outer (
    .clk      (clk),
    .en       (adv),
    .radicand (orad4),
    .root     (dxo)
  );

  rrs_isqrt #(.ROOT_W(ROOT_W), .STEP_N(rrs_pkg::SQRT_STEPS)) u_sqrt_inner (
    .clk      (clk),
    .en       (adv),
    .radicand (irad4),
    .root     (dxi)
  );

  logic        sd_v   [SQ_STAGES];
  logic        sd_win [SQ_STAGES];
  logic        sd_om  [SQ_STAGES];
  logic        sd_im  [SQ_STAGES];
  logic [11:0] sd_y   [SQ_STAGES];

  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_side
    if (k == 0) begin : g_head
      always_ff @(posedge clk) begin
        if (rst) begin
          sd_v[k] <= 1'b0;
        end else if (adv) begin
          sd_v[k] <= v4;
        end
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          sd_win[k] <= win4;
          sd_om[k]  <= om4;
          sd_im[k]  <= im4;
          sd_y[k]   <= y4;
        end
      end
    end else begin : g_tail
      always_ff @(posedge clk) begin
        if (rst) begin
          sd_v[k] <= 1'b0;
        end else if (adv) begin
          sd_v[k] <= sd_v[k-1];
        end
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          sd_win[k] <= sd_win[k-1];
          sd_om[k]  <= sd_om[k-1];
          sd_im[k]  <= sd_im[k-1];
          sd_y[k]   <= sd_y[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Clamped span ends of both circles. A row outside the window, or one the outer circle
  // misses, leaves no span and its valid bit is dropped here.
  // ---------------------------------------------------------------------------------------
  logic               va, ima;
  logic [11:0]        ya;
  logic [12:0]        so_a, eo_a, si_a, ei_a;
  logic signed [15:0] cxs;

  assign cxs = $signed({{2{center_x[13]}}, center_x});

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (adv) begin
      va <= sd_v[SQ_STAGES-1] && sd_win[SQ_STAGES-1] && !sd_om[SQ_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ya   <= sd_y[SQ_STAGES-1];
      ima  <= sd_im[SQ_STAGES-1];
      so_a <= clamp_u(cxs - $signed({3'b000, dxo}), d_wmax);
      eo_a <= clamp_u(cxs + $signed({3'b000, dxo}), d_wmax);
      si_a <= clamp_u(cxs - $signed({3'b000, dxi}), d_wmax);
      ei_a <= clamp_u(cxs + $signed({3'b000, dxi}), d_wmax);
    end
  end

  // ---------------------------------------------------------------------------------------
  // Span selection. With no hole, or a hole that misses the row or lies beside the outer
  // span, the whole outer span is painted. Otherwise the left piece is painted when it is
  // not empty, and the right piece, from the inner end to the outer end, always.
  // ---------------------------------------------------------------------------------------
  logic        one_span, two_span;
  logic [12:0] s0_start, s0_end;

  always_comb begin
    one_span = (d_inner == 12'd0) || ima || (si_a > eo_a) || (ei_a < so_a);
    two_span = !one_span && (si_a > so_a);
    if (one_span) begin
      s0_start = so_a;
      s0_end   = eo_a;
    end else if (two_span) begin
      s0_start = so_a;
      s0_end   = si_a - 13'd1;
    end else begin
      s0_start = ei_a;
      s0_end   = eo_a;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Output register. It holds a whole row; a two-span row sends its first span, then its
  // second, and the pipeline reloads the register in the cycle the last beat is taken.
  // ---------------------------------------------------------------------------------------
  logic [11:0] e_row, e_s0, e_e0, e_s1, e_e1;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
      e_phase <= 1'b0;
      e_two   <= 1'b0;
    end else if (adv) begin
      e_valid <= va;
      e_phase <= 1'b0;
      e_two   <= two_span;
    end else if (span_out.ready) begin
      e_phase <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_row <= ya;
      e_s0  <= s0_start[11:0];
      e_e0  <= s0_end[11:0];
      e_s1  <= ei_a[11:0];
      e_e1  <= eo_a[11:0];
    end
  end

  assign span_out.valid       = e_valid;
  assign span_out.span_row    = e_row;
  assign span_out.span_start  = e_phase ? e_s1 : e_s0;
  assign span_out.span_end    = e_phase ? e_e1 : e_e0;
  assign span_out.pixel_value = fill_level;
  assign span_out.last_span   = !e_two || e_phase;

  // ---------------------------------------------------------------------------------------
  // Checks.
  // ---------------------------------------------------------------------------------------
  a_span_order: assert property (@(posedge clk) disable iff (rst)
    span_out.valid |-> (span_out.span_start <= span_out.span_end))
    else $error("span start lies beyond span end");

  // The input waits while the output holds a span that is not taken, or while the first span of a
  // two-span row is leaving.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !row_in.ready |-> (span_out.valid && !(span_out.ready && span_out.last_span)))
    else $error("input stalled without a pending output beat");

  a_pair_follows: assert property (@(posedge clk) disable iff (rst)
    (span_out.valid && span_out.ready && !span_out.last_span)
      |=> (span_out.valid && span_out.last_span))
    else $error("first span of a row not followed by its last span");

  a_pair_row: assert property (@(posedge clk) disable iff (rst)
    (span_out.valid && span_out.ready && !span_out.last_span)
      |=> (span_out.span_row == $past(span_out.span_row)))
    else $error("second span of a row carries another row");

endmodule
